>>> hw/rtl/fpalu_pkg.sv
// Shared types and constants for the fixed-point format ALU.
`timescale 1ns / 1ps
package fpalu_pkg;

    // Width of a configuration register and of the format fields of a result.
    localparam int CFG_W = 5;
    localparam int FMT_W = 6;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_A_WIDTH = 2'd0;
    localparam logic [1:0] REG_A_INT   = 2'd1;
    localparam logic [1:0] REG_B_WIDTH = 2'd2;
    localparam logic [1:0] REG_B_INT   = 2'd3;

    // Operation codes.
    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    // Operand formats as written by configuration.
    typedef struct packed {
        logic [CFG_W-1:0] a_width;
        logic [CFG_W-1:0] a_int;
        logic [CFG_W-1:0] b_width;
        logic [CFG_W-1:0] b_int;
    } t_cfg;

    // Per-item control decoded at the front stage.
    typedef struct packed {
        t_cmd             cmd;
        logic [FMT_W-1:0] rw;
        logic [FMT_W-1:0] ri;
        logic             neg;
        logic             bz;
    } t_ctl;

    // Control carried alongside the divider stages.
    typedef struct packed {
        t_ctl ctl;
        logic lt;
        logic eq;
        logic ng;
    } t_side;

endpackage

>>> hw/rtl/fpalu_front.sv
// Front stage: format decode, operand sign extension, alignment and magnitudes.
`timescale 1ns / 1ps
module fpalu_front
    import fpalu_pkg::*;
#(
    parameter int W   = 30,
    parameter int RVW = 61,
    parameter int NW  = 60
) (
    input  logic                  i_clk,
    input  logic                  i_adv,
    input  t_cfg                  i_cfg,
    input  t_cmd                  i_cmd,
    input  logic [W-1:0]          i_a_value,
    input  logic [W-1:0]          i_b_value,
    output t_ctl                  o_ctl,
    output logic signed [RVW-1:0] o_a_al,
    output logic signed [RVW-1:0] o_b_al,
    output logic [W-1:0]          o_ma,
    output logic [W-1:0]          o_mb,
    output logic [NW-1:0]         o_num
);

    logic [FMT_W-1:0]      wa, ia, wb, ib, fa, fb, asi, asf, ka, kb;
    logic signed [W-1:0]   a_sh, b_sh, a_s, b_s;
    logic signed [RVW-1:0] a_x, b_x;
    t_ctl                  n_ctl;
    logic signed [RVW-1:0] n_a_al, n_b_al;
    logic [W-1:0]          n_ma, n_mb;
    logic [NW-1:0]         n_num;
    t_ctl                  r_ctl;
    logic signed [RVW-1:0] r_a_al, r_b_al;
    logic [W-1:0]          r_ma, r_mb;
    logic [NW-1:0]         r_num;

    // Effective formats: a zero width counts as one, widths and integer bits saturate.
    always_comb begin
        wa = (i_cfg.a_width == '0) ? FMT_W'(1) :
             ((FMT_W'(i_cfg.a_width) > FMT_W'(W)) ? FMT_W'(W) : FMT_W'(i_cfg.a_width));
        wb = (i_cfg.b_width == '0) ? FMT_W'(1) :
             ((FMT_W'(i_cfg.b_width) > FMT_W'(W)) ? FMT_W'(W) : FMT_W'(i_cfg.b_width));
        ia = (FMT_W'(i_cfg.a_int) > wa) ? wa : FMT_W'(i_cfg.a_int);
        ib = (FMT_W'(i_cfg.b_int) > wb) ? wb : FMT_W'(i_cfg.b_int);
        fa = wa - ia;
        fb = wb - ib;
        asi = ((ia > ib) ? ia : ib) + FMT_W'(1);
        asf = (fa > fb) ? fa : fb;
    end

    // Operands sign-extended from the top bit of their format, then aligned.
    always_comb begin
        ka = FMT_W'(W) - wa;
        kb = FMT_W'(W) - wb;
        a_sh = i_a_value << ka;
        b_sh = i_b_value << kb;
        a_s = a_sh >>> ka;
        b_s = b_sh >>> kb;
        a_x = {{(RVW-W){a_s[W-1]}}, a_s};
        b_x = {{(RVW-W){b_s[W-1]}}, b_s};
        n_a_al = a_x <<< (asf - fa);
        n_b_al = b_x <<< (asf - fb);
        n_ma = a_s[W-1] ? (W'(0) - a_s) : a_s;
        n_mb = b_s[W-1] ? (W'(0) - b_s) : b_s;
        n_num = NW'(n_ma) << fb;
    end

    // Result format for each operation.
    always_comb begin
        n_ctl.cmd = i_cmd;
        n_ctl.neg = a_s[W-1] ^ b_s[W-1];
        n_ctl.bz = (b_s == '0);
        unique case (i_cmd)
            CMD_ADD, CMD_SUB: begin
                n_ctl.ri = asi;
                n_ctl.rw = asi + asf;
            end
            CMD_MUL: begin
                n_ctl.ri = ia + ib;
                n_ctl.rw = wa + wb;
            end
            default: begin
                n_ctl.ri = ia + fb + FMT_W'(1);
                n_ctl.rw = wa + fb + FMT_W'(1);
            end
        endcase
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl <= n_ctl;
            r_a_al <= n_a_al;
            r_b_al <= n_b_al;
            r_ma <= n_ma;
            r_mb <= n_mb;
            r_num <= n_num;
        end
    end

    assign o_ctl = r_ctl;
    assign o_a_al = r_a_al;
    assign o_b_al = r_b_al;
    assign o_ma = r_ma;
    assign o_mb = r_mb;
    assign o_num = r_num;

endmodule

>>> hw/rtl/fpalu_div_stage.sv
// One registered stage of the restoring divider, a few quotient bits per stage.
`timescale 1ns / 1ps
module fpalu_div_stage #(
    parameter int W  = 30,
    parameter int NW = 60,
    parameter int K  = 4
) (
    input  logic          i_clk,
    input  logic          i_adv,
    input  logic [W-1:0]  i_rem,
    input  logic [NW-1:0] i_num,
    input  logic [NW-1:0] i_quo,
    input  logic [W-1:0]  i_den,
    output logic [W-1:0]  o_rem,
    output logic [NW-1:0] o_num,
    output logic [NW-1:0] o_quo,
    output logic [W-1:0]  o_den
);

    logic [W:0]    t;
    logic [W-1:0]  n_rem, r_rem;
    logic [NW-1:0] n_num, n_quo, r_num, r_quo;
    logic [W-1:0]  r_den;

    // Shift in one numerator bit per step and subtract when the divisor fits.
    always_comb begin
        n_rem = i_rem;
        n_num = i_num;
        n_quo = i_quo;
        t = '0;
        for (int s = 0; s < K; s++) begin
            t = {n_rem, n_num[NW-1]};
            n_num = n_num << 1;
            if (t >= {1'b0, i_den}) begin
                t = t - {1'b0, i_den};
                n_quo = {n_quo[NW-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[NW-2:0], 1'b0};
            end
            n_rem = t[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_quo <= n_quo;
            r_den <= i_den;
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_quo = r_quo;
    assign o_den = r_den;

endmodule

>>> hw/rtl/fixed_point_format_alu.sv
// Top level of the fixed-point format ALU: configuration, pipeline and output stage.
// An item passes the front stage register, the divider stages and the output register
// between input transfer and the presented result.
// Throughput: one item per cycle; the divider retires four quotient bits per stage.
// The whole pipeline holds while a finished result is stalled at the output register.
// Reset (synchronous, active low) clears all valid bits and loads formats 16/8 for a and b.
`timescale 1ns / 1ps
module fixed_point_format_alu
    import fpalu_pkg::*;
#(
    parameter int MAX_OPERAND_WIDTH = 30
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [CFG_W-1:0]                i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_cmd,
    input  logic signed [MAX_OPERAND_WIDTH-1:0] i_a_value,
    input  logic signed [MAX_OPERAND_WIDTH-1:0] i_b_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [2*MAX_OPERAND_WIDTH:0] o_result_value,
    output logic [FMT_W-1:0]                o_result_width,
    output logic [FMT_W-1:0]                o_result_integer_bits,
    output logic                            o_a_less_than_b,
    output logic                            o_a_equals_b,
    output logic                            o_divide_by_zero
);

    localparam int W   = MAX_OPERAND_WIDTH;
    localparam int RVW = 2 * W + 1;
    localparam int K   = 4;
    localparam int NST = (2 * W + K - 1) / K;
    localparam int NW  = NST * K;

    logic                  adv;
    t_cfg                  r_cfg;
    logic                  r_fv;
    logic [NST-1:0]        r_sv;
    t_ctl                  f_ctl;
    logic signed [RVW-1:0] f_a_al, f_b_al;
    logic [W-1:0]          f_ma, f_mb;
    logic [NW-1:0]         f_num;
    logic signed [RVW-1:0] sum, diff;
    logic [2*W-1:0]        prod;
    t_side                 n_side;
    logic [RVW-1:0]        n_mag;
    t_side                 r_side [NST];
    logic [RVW-1:0]        r_mag  [NST];
    logic [W-1:0]          d_rem  [NST+1];
    logic [NW-1:0]         d_num  [NST+1];
    logic [NW-1:0]         d_quo  [NST+1];
    logic [W-1:0]          d_den  [NST+1];
    t_side                 l_side;
    logic [RVW-1:0]        l_mag, fin_val, fin_sh;
    logic                  l_neg;
    logic [FMT_W:0]        fin_k;
    logic                  r_ov;
    logic signed [RVW-1:0] r_val;
    t_side                 r_oside;

    // The pipeline moves whenever the output register is empty or its result is taken.
    assign adv = !r_ov || !i_out_stall;
    assign o_in_stall = !adv;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.a_width <= CFG_W'(16);
            r_cfg.a_int <= CFG_W'(8);
            r_cfg.b_width <= CFG_W'(16);
            r_cfg.b_int <= CFG_W'(8);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_A_WIDTH: r_cfg.a_width <= i_cfg_data;
                REG_A_INT:   r_cfg.a_int <= i_cfg_data;
                REG_B_WIDTH: r_cfg.b_width <= i_cfg_data;
                default:     r_cfg.b_int <= i_cfg_data;
            endcase
        end
    end

    fpalu_front #(.W(W), .RVW(RVW), .NW(NW)) u_front (
        .i_clk     (i_clk),
        .i_adv     (adv),
        .i_cfg     (r_cfg),
        .i_cmd     (t_cmd'(i_cmd)),
        .i_a_value (i_a_value),
        .i_b_value (i_b_value),
        .o_ctl     (f_ctl),
        .o_a_al    (f_a_al),
        .o_b_al    (f_b_al),
        .o_ma      (f_ma),
        .o_mb      (f_mb),
        .o_num     (f_num)
    );

    // Add, subtract, compare flags and the magnitude product.
    always_comb begin
        sum = f_a_al + f_b_al;
        diff = f_a_al - f_b_al;
        prod = (2*W)'(f_ma) * (2*W)'(f_mb);
        n_side.ctl = f_ctl;
        n_side.lt = diff[RVW-1];
        n_side.eq = (diff == '0);
        n_side.ng = 1'b0;
        unique case (f_ctl.cmd)
            CMD_ADD: n_mag = sum;
            CMD_SUB: n_mag = diff;
            CMD_MUL: begin
                n_mag = RVW'(prod);
                n_side.ng = f_ctl.neg;
            end
            default: n_mag = '0;
        endcase
    end

    // Divider stages.
    assign d_rem[0] = '0;
    assign d_num[0] = f_num;
    assign d_quo[0] = '0;
    assign d_den[0] = f_mb;

    for (genvar g = 0; g < NST; g++) begin : g_div
        fpalu_div_stage #(.W(W), .NW(NW), .K(K)) u_stage (
            .i_clk (i_clk),
            .i_adv (adv),
            .i_rem (d_rem[g]),
            .i_num (d_num[g]),
            .i_quo (d_quo[g]),
            .i_den (d_den[g]),
            .o_rem (d_rem[g+1]),
            .o_num (d_num[g+1]),
            .o_quo (d_quo[g+1]),
            .o_den (d_den[g+1])
        );
    end

    // The other results are carried alongside the divider stages.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= n_side;
            r_mag[0] <= n_mag;
            for (int g = 1; g < NST; g++) begin
                r_side[g] <= r_side[g-1];
                r_mag[g] <= r_mag[g-1];
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
            r_sv <= '0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_fv <= i_in_valid;
            r_sv <= {r_sv[NST-2:0], r_fv};
            r_ov <= r_sv[NST-1];
        end
    end

    // Final sign, zero divisor and truncation to the result format.
    always_comb begin
        l_side = r_side[NST-1];
        if (l_side.ctl.cmd == CMD_DIV) begin
            l_mag = {1'b0, d_quo[NST][2*W-1:0]};
            l_neg = l_side.ctl.neg;
        end else begin
            l_mag = r_mag[NST-1];
            l_neg = l_side.ng;
        end
        fin_val = l_neg ? (RVW'(0) - l_mag) : l_mag;
        if ((l_side.ctl.cmd == CMD_DIV) && l_side.ctl.bz) begin
            fin_val = '0;
        end
        fin_k = (FMT_W+1)'(RVW) - {1'b0, l_side.ctl.rw};
        fin_sh = fin_val << fin_k;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_val <= $signed(fin_sh) >>> fin_k;
            r_oside <= l_side;
        end
    end

    assign o_out_valid = r_ov;
    assign o_result_value = r_val;
    assign o_result_width = r_oside.ctl.rw;
    assign o_result_integer_bits = r_oside.ctl.ri;
    assign o_a_less_than_b = r_oside.lt;
    assign o_a_equals_b = r_oside.eq;
    assign o_divide_by_zero = (r_oside.ctl.cmd == CMD_DIV) && r_oside.ctl.bz;

endmodule
